>>> hw/rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

	// Default build parameters.
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam int ADDR_WIDTH_DEF = 32;

	// Field and register widths.
	localparam int OPCODE_W   = 2;
	localparam int ADDRESS_W  = 32;
	localparam int STATUS_W   = 2;
	localparam int BASE_W     = 32;
	localparam int BSIZE_W    = 16;
	localparam int BCOUNT_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register reset values.
	localparam logic [BASE_W-1:0]   BASE_RST   = '0;
	localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 16'd64;
	localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 11'd1024;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BSIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BCOUNT = 2'd2;

	// Operation codes.
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RESET = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_AMUL,
		S_AADD,
		S_FCHK,
		S_FDIV,
		S_FPUSH,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic list_reset;
		logic set_nop;
		logic alloc_pick;
		logic alloc_empty;
		logic alloc_mul;
		logic alloc_add;
		logic free_outside;
		logic div_init;
		logic div_step;
		logic free_push;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_alloc;
		logic outside;
	} stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/fbpa_dp.sv
`default_nettype none

module fbpa_dp #(
	parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [fbpa_pkg::ADDRESS_W-1:0]      address,
	input  wire fbpa_pkg::cmd_t                      cmd,
	output fbpa_pkg::stat_t                          stat,
	output logic [fbpa_pkg::STATUS_W-1:0]            status,
	output logic [fbpa_pkg::ADDRESS_W-1:0]           block_address
);

	localparam int AW = ADDR_WIDTH;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = fbpa_pkg::BSIZE_W + CW;
	localparam int OW = fbpa_pkg::BSIZE_W + IW;
	localparam int PW = fbpa_pkg::BSIZE_W + IW;

	logic [fbpa_pkg::BASE_W-1:0]   base_q;
	logic [fbpa_pkg::BSIZE_W-1:0]  bsize_q;
	logic [fbpa_pkg::BCOUNT_W-1:0] bcount_q;

	logic [CW-1:0] fresh_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] qcnt_q;

	logic [AW-1:0]                   addr_q;
	logic [EW-1:0]                   extent_q;
	logic                            src_fresh_q;
	logic [IW-1:0]                   idx_q;
	logic [IW-1:0]                   rd_q;
	logic [PW-1:0]                   prod_q;
	logic [OW-1:0]                   rem_q;
	logic [OW-1:0]                   dsh_q;
	logic [IW-1:0]                   quo_q;
	logic [fbpa_pkg::STATUS_W-1:0]   res_status_q;
	logic [fbpa_pkg::ADDRESS_W-1:0]  res_addr_q;
	logic [fbpa_pkg::STATUS_W-1:0]   status_q;
	logic [fbpa_pkg::ADDRESS_W-1:0]  baddr_q;

	logic [IW-1:0] mem [MAX_BLOCKS];

	logic [CW-1:0] eff;
	logic [CW-1:0] fresh_left;
	logic [CW:0]   total;
	logic          full;
	logic [EW-1:0] extent_d;
	logic [63:0]   addr64;
	logic [63:0]   base64;
	logic [AW-1:0] base_aw;
	logic [AW-1:0] off;
	logic [63:0]   off64;
	logic [IW-1:0] idx_sel;
	logic [63:0]   prod64;
	logic [AW-1:0] sum;
	logic [63:0]   sum64;
	logic          take_fresh;

	always_comb begin
		if (32'(bcount_q) > 32'(MAX_BLOCKS)) begin
			eff = CW'(MAX_BLOCKS);
		end else begin
			eff = CW'(bcount_q);
		end
	end

	assign fresh_left = (eff > fresh_q) ? (eff - fresh_q) : '0;
	assign take_fresh = (fresh_left != '0);
	assign total      = {1'b0, fresh_left} + {1'b0, qcnt_q};
	assign full       = (total >= {1'b0, eff}) || (qcnt_q >= CW'(MAX_BLOCKS));
	assign extent_d   = EW'(bsize_q) * EW'(eff);

	// Addresses live in the ADDR_WIDTH space inside the block.
	assign addr64  = 64'(address);
	assign base64  = 64'(base_q);
	assign base_aw = base64[AW-1:0];
	assign off     = addr_q - base_aw;
	assign off64   = 64'(off);

	assign idx_sel = src_fresh_q ? idx_q : rd_q;
	assign prod64  = 64'(prod_q);
	assign sum     = base_aw + prod64[AW-1:0];
	assign sum64   = 64'(sum);

	assign stat.can_alloc = take_fresh || (qcnt_q != '0);
	assign stat.outside   = (addr_q < base_aw) || (off64 >= 64'(extent_q)) ||
		(bsize_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= fbpa_pkg::BASE_RST;
			bsize_q  <= fbpa_pkg::BSIZE_RST;
			bcount_q <= fbpa_pkg::BCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fbpa_pkg::CFG_BASE:   base_q   <= cfg_data[fbpa_pkg::BASE_W-1:0];
				fbpa_pkg::CFG_BSIZE:  bsize_q  <= cfg_data[fbpa_pkg::BSIZE_W-1:0];
				fbpa_pkg::CFG_BCOUNT: bcount_q <= cfg_data[fbpa_pkg::BCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Free list pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			qcnt_q  <= '0;
		end else if (cmd.list_reset) begin
			fresh_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			qcnt_q  <= '0;
		end else if (cmd.alloc_pick) begin
			if (take_fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end else begin
				head_q <= (head_q == IW'(MAX_BLOCKS - 1)) ? '0 : head_q + IW'(1);
				qcnt_q <= qcnt_q - CW'(1);
			end
		end else if (cmd.free_push && !full) begin
			tail_q <= (tail_q == IW'(MAX_BLOCKS - 1)) ? '0 : tail_q + IW'(1);
			qcnt_q <= qcnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.free_push && !full) begin
			mem[tail_q] <= quo_q;
		end
		if (cmd.alloc_pick && !take_fresh) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q   <= addr64[AW-1:0];
			extent_q <= extent_d;
		end
		if (cmd.alloc_pick) begin
			src_fresh_q <= take_fresh;
			idx_q       <= fresh_q[IW-1:0];
		end
		if (cmd.alloc_mul) begin
			prod_q <= PW'(idx_sel) * PW'(bsize_q);
		end
		if (cmd.div_init) begin
			rem_q <= off64[OW-1:0];
			dsh_q <= OW'(bsize_q) << (IW - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			// One quotient bit per cycle, most significant first.
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= IW'({quo_q, 1'b1});
			end else begin
				quo_q <= IW'({quo_q, 1'b0});
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_nop) begin
			res_status_q <= fbpa_pkg::ST_OK;
			res_addr_q   <= '0;
		end else if (cmd.alloc_empty) begin
			res_status_q <= fbpa_pkg::ST_EMPTY;
			res_addr_q   <= '0;
		end else if (cmd.alloc_add) begin
			res_status_q <= fbpa_pkg::ST_OK;
			res_addr_q   <= sum64[fbpa_pkg::ADDRESS_W-1:0];
		end else if (cmd.free_outside) begin
			res_status_q <= fbpa_pkg::ST_OUTSIDE;
			res_addr_q   <= '0;
		end else if (cmd.free_push) begin
			res_status_q <= full ? fbpa_pkg::ST_FULL : fbpa_pkg::ST_OK;
			res_addr_q   <= '0;
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			baddr_q  <= res_addr_q;
		end
	end

	assign status        = status_q;
	assign block_address = baddr_q;

endmodule

`default_nettype wire

>>> hw/rtl/fbpa_ctrl.sv
`default_nettype none

module fbpa_ctrl #(
	parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [fbpa_pkg::OPCODE_W-1:0]   opcode,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	input  wire fbpa_pkg::stat_t                 stat,
	output fbpa_pkg::cmd_t                       cmd
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int SW = (IW > 1) ? $clog2(IW) : 1;

	fbpa_pkg::state_t state_q;
	fbpa_pkg::state_t state_d;
	logic [SW-1:0]    cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fbpa_pkg::S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						fbpa_pkg::OP_ALLOC: state_d = fbpa_pkg::S_ALLOC;
						fbpa_pkg::OP_FREE:  state_d = fbpa_pkg::S_FCHK;
						default:            state_d = fbpa_pkg::S_OUT;
					endcase
				end
			end
			fbpa_pkg::S_ALLOC: begin
				state_d = stat.can_alloc ? fbpa_pkg::S_AMUL : fbpa_pkg::S_OUT;
			end
			fbpa_pkg::S_AMUL: state_d = fbpa_pkg::S_AADD;
			fbpa_pkg::S_AADD: state_d = fbpa_pkg::S_OUT;
			fbpa_pkg::S_FCHK: begin
				state_d = stat.outside ? fbpa_pkg::S_OUT : fbpa_pkg::S_FDIV;
			end
			fbpa_pkg::S_FDIV: begin
				if (cnt_q == '0) begin
					state_d = fbpa_pkg::S_FPUSH;
				end
			end
			fbpa_pkg::S_FPUSH: state_d = fbpa_pkg::S_OUT;
			fbpa_pkg::S_OUT: begin
				if (out_free) begin
					state_d = fbpa_pkg::S_IDLE;
				end
			end
			default: state_d = fbpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			fbpa_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (opcode == fbpa_pkg::OP_RESET) begin
						cmd.list_reset = 1'b1;
					end
					if (opcode != fbpa_pkg::OP_ALLOC && opcode != fbpa_pkg::OP_FREE) begin
						cmd.set_nop = 1'b1;
					end
				end
			end
			fbpa_pkg::S_ALLOC: begin
				if (stat.can_alloc) begin
					cmd.alloc_pick = 1'b1;
				end else begin
					cmd.alloc_empty = 1'b1;
				end
			end
			fbpa_pkg::S_AMUL: cmd.alloc_mul = 1'b1;
			fbpa_pkg::S_AADD: cmd.alloc_add = 1'b1;
			fbpa_pkg::S_FCHK: begin
				if (stat.outside) begin
					cmd.free_outside = 1'b1;
				end else begin
					cmd.div_init = 1'b1;
				end
			end
			fbpa_pkg::S_FDIV:  cmd.div_step = 1'b1;
			fbpa_pkg::S_FPUSH: cmd.free_push = 1'b1;
			fbpa_pkg::S_OUT:   cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbpa_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= SW'(IW - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - SW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != fbpa_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool with a first-in first-out free list.
// Each transfer on the input channel (in_valid, in_stall, opcode, address) carries one
// operation: allocate, free or reset of the free list. Each operation yields exactly one
// transfer on the output channel (out_valid, out_stall, status, block_address).
// The pool is set up through a write-only register port (cfg_we, cfg_index, cfg_data):
// base address, block size and block count. The user must write it only while the block
// is idle; the block itself does not enforce this.
// A free runs a restoring divider that turns an offset into a block index, one quotient
// bit per cycle; allocate takes a step each for the free-list memory read, the index
// times size multiply and the base add.
// One operation is in flight at a time; the next input transfer is taken in the cycle after
// the result is written to the output register.
// The output register holds its result while out_stall is high; a finished operation waits
// for it to drain, and the input stays stalled meanwhile.
// Asynchronous reset restores the register defaults and restarts the free list with every
// block up to the count free, as a reset operation does. No clearing pass is needed.
`default_nettype none

module fixed_block_pool_allocator_unit #(
	parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [fbpa_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [fbpa_pkg::ADDRESS_W-1:0]   address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [fbpa_pkg::STATUS_W-1:0]         status,
	output logic [fbpa_pkg::ADDRESS_W-1:0]        block_address
);

	fbpa_pkg::cmd_t  cmd;
	fbpa_pkg::stat_t stat;

	// The controller sequences each operation; the datapath holds the registers,
	// the free-list memory, the multiplier and the divider.
	fbpa_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	fbpa_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.address      (address),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.block_address(block_address)
	);

endmodule

`default_nettype wire

>>> hw/rtl/fbpa_checker.sv
`default_nettype none

module fbpa_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [fbpa_pkg::STATUS_W-1:0]    status,
	input wire logic [fbpa_pkg::ADDRESS_W-1:0]   block_address
);

	// A stalled result stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_address))
		else $error("stalled result changed or dropped");

	// Every operation leaves the idle state on its transfer, so the input stalls right after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again in the cycle after a transfer");

	// Only a successful allocate carries a nonzero address.
	a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fbpa_pkg::ST_OK |-> block_address == '0)
		else $error("error result with nonzero block address");

	// A new result cannot appear while the input side is still idle-ready with no work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall && !in_valid |=> !out_valid)
		else $error("result appeared without an operation in flight");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.block_address(block_address)
);

`default_nettype wire
